>>> rtl/link_block_framer_macros.svh
// assertion macros for the link block framer
`ifndef LINK_BLOCK_FRAMER_MACROS_SVH
`define LINK_BLOCK_FRAMER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LBF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("link block framer check failed");

// next-cycle implication, sampled on clk, off during reset
`define LBF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("link block framer check failed");

`endif

>>> rtl/lbf_pkg.sv
// shared constants and command/status types for the link block framer
package lbf_pkg;

    localparam int unsigned WORDS_PER_FRAME = 7;
    localparam int unsigned FPOS_W = $clog2(WORDS_PER_FRAME);
    localparam int unsigned WPOS_W = $clog2(WORDS_PER_FRAME + 1);

    localparam int unsigned WORD_W    = 16;
    localparam int unsigned BYTES_W   = 8;
    localparam int unsigned WORDS_W   = BYTES_W - 1;
    localparam int unsigned COV_W     = WORDS_W + 1;
    localparam int unsigned CFG_W     = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned FCNT_W    = CFG_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_BEFORE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_AFTER  = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] EMPTY_RESET = CFG_W'(2);

    localparam logic [WORD_W-1:0] CTRL_EMPTY = 16'h0000;
    localparam logic [WORD_W-1:0] CTRL_INIT  = 16'hBBBB;
    localparam logic [WORD_W-1:0] CTRL_DATA  = 16'h8888;
    localparam logic [WORD_W-1:0] INIT_TAG   = 16'h0081;

    localparam logic SEL_CTRL = 1'b0;
    localparam logic SEL_DATA = 1'b1;

    typedef struct packed {
        logic accept_start;
        logic accept_data;
        logic emit_frame;
        logic emit_hdr;
        logic emit_word;
        logic emit_pad;
    } lbf_cmd_t;

    typedef struct packed {
        logic out_free;
        logic active;
        logic hdr_pending;
        logic frame_last;
        logic hdr_last;
        logic word_pads;
        logic pad_last;
    } lbf_stat_t;

endpackage

>>> rtl/lbf_ctrl.sv
// controller state machine of the link block framer
module lbf_ctrl
    import lbf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      op,
    output logic      in_stall,
    input  lbf_stat_t stat,
    output lbf_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FRAMES = 3'd1;
    localparam logic [2:0] ST_HDR    = 3'd2;
    localparam logic [2:0] ST_WORD   = 3'd3;
    localparam logic [2:0] ST_PAD    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (!op)
                    begin
                        cmd.accept_start = 1'b1;
                        state_next       = ST_FRAMES;
                    end
                    else if (stat.active)
                    begin
                        cmd.accept_data = 1'b1;
                        state_next      = stat.hdr_pending ? ST_HDR : ST_WORD;
                    end
                end
            end
            ST_FRAMES:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_frame = 1'b1;
                    if (stat.frame_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HDR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_hdr = 1'b1;
                    if (stat.hdr_last)
                    begin
                        state_next = ST_WORD;
                    end
                end
            end
            ST_WORD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_word = 1'b1;
                    state_next    = stat.word_pads ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_pad = 1'b1;
                    if (stat.pad_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/lbf_datapath.sv
// datapath of the link block framer: block counters, config and output register
module lbf_datapath
    import lbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [BYTES_W-1:0]   block_bytes,
    input  logic [WORD_W-1:0]    data_word,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic                 stream_sel,
    output logic [WORD_W-1:0]    word_out,
    output logic                 last,
    input  lbf_cmd_t             cmd,
    output lbf_stat_t            stat
);

`include "link_block_framer_macros.svh"

    logic [CFG_W-1:0]   empty_before_reg;
    logic [CFG_W-1:0]   empty_after_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [WORDS_W-1:0] block_words_reg;
    logic [WORDS_W-1:0] words_left_reg;
    logic [FPOS_W-1:0]  frame_pos_reg;
    logic               hdr_pending_reg;
    logic [COV_W-1:0]   covered_reg;
    logic [FCNT_W-1:0]  fcnt_reg;
    logic [WPOS_W-1:0]  wpos_reg;
    logic [WORD_W-1:0]  dword_reg;
    logic               out_valid_reg;
    logic               out_sel_reg;
    logic [WORD_W-1:0]  out_word_reg;
    logic               out_last_reg;

    logic               out_valid_next;
    logic               out_free;
    logic               emit_any;
    logic [FCNT_W-1:0]  frame_total;
    logic               is_init;
    logic               wpos_end;
    logic [WORD_W-1:0]  frame_word;
    logic [COV_W-1:0]   covered_next;
    logic [FPOS_W-1:0]  fpos_inc;
    logic [WORDS_W-1:0] start_words;

    assign out_free    = !out_valid_reg || !out_stall;
    assign emit_any    = cmd.emit_frame || cmd.emit_hdr || cmd.emit_word || cmd.emit_pad;
    assign frame_total = {1'b0, empty_before_reg} + {1'b0, empty_after_reg};
    assign is_init     = fcnt_reg == {1'b0, empty_before_reg};
    assign wpos_end    = wpos_reg == WPOS_W'(WORDS_PER_FRAME);
    assign covered_next = covered_reg + COV_W'(WORDS_PER_FRAME);
    assign fpos_inc    = (frame_pos_reg == FPOS_W'(WORDS_PER_FRAME - 1)) ?
                         '0 : frame_pos_reg + FPOS_W'(1);
    assign start_words = block_bytes[BYTES_W-1:1];

    always_comb
    begin
        frame_word = '0;
        if (wpos_reg == '0)
        begin
            frame_word = is_init ? CTRL_INIT : CTRL_EMPTY;
        end
        else if (is_init && wpos_reg == WPOS_W'(1))
        begin
            frame_word = {{(WORD_W - BYTES_W){1'b0}}, bytes_reg};
        end
        else if (is_init && wpos_reg == WPOS_W'(2))
        begin
            frame_word = INIT_TAG;
        end
    end

    assign stat.out_free    = out_free;
    assign stat.active      = words_left_reg != '0;
    assign stat.hdr_pending = hdr_pending_reg;
    assign stat.frame_last  = (fcnt_reg == frame_total) && wpos_end;
    assign stat.hdr_last    = covered_next >= {1'b0, block_words_reg};
    assign stat.word_pads   = (words_left_reg == WORDS_W'(1)) && (fpos_inc != '0);
    assign stat.pad_last    = fpos_inc == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_before_reg <= EMPTY_RESET;
            empty_after_reg  <= EMPTY_RESET;
            words_left_reg   <= '0;
            block_words_reg  <= '0;
            frame_pos_reg    <= '0;
            hdr_pending_reg  <= 1'b0;
            fcnt_reg         <= '0;
            wpos_reg         <= '0;
            covered_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EMPTY_BEFORE: empty_before_reg <= cfg_data;
                    REG_EMPTY_AFTER:  empty_after_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.accept_start)
            begin
                block_words_reg <= start_words;
                words_left_reg  <= start_words;
                frame_pos_reg   <= '0;
                hdr_pending_reg <= start_words != '0;
                fcnt_reg        <= '0;
                wpos_reg        <= '0;
            end
            if (cmd.accept_data)
            begin
                covered_reg <= '0;
            end
            if (cmd.emit_frame)
            begin
                if (wpos_end)
                begin
                    wpos_reg <= '0;
                    fcnt_reg <= fcnt_reg + FCNT_W'(1);
                end
                else
                begin
                    wpos_reg <= wpos_reg + WPOS_W'(1);
                end
            end
            if (cmd.emit_hdr)
            begin
                covered_reg <= covered_next;
                if (stat.hdr_last)
                begin
                    hdr_pending_reg <= 1'b0;
                end
            end
            if (cmd.emit_word)
            begin
                words_left_reg <= words_left_reg - WORDS_W'(1);
                frame_pos_reg  <= fpos_inc;
            end
            if (cmd.emit_pad)
            begin
                frame_pos_reg <= fpos_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_start)
        begin
            bytes_reg <= block_bytes;
        end
        if (cmd.accept_data)
        begin
            dword_reg <= data_word;
        end
    end

    // output beat register
    assign out_valid_next = emit_any ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_frame)
        begin
            out_sel_reg  <= (wpos_reg == '0) ? SEL_CTRL : SEL_DATA;
            out_word_reg <= frame_word;
            out_last_reg <= stat.frame_last;
        end
        else if (cmd.emit_hdr)
        begin
            out_sel_reg  <= SEL_CTRL;
            out_word_reg <= CTRL_DATA;
            out_last_reg <= 1'b0;
        end
        else if (cmd.emit_word)
        begin
            out_sel_reg  <= SEL_DATA;
            out_word_reg <= dword_reg;
            out_last_reg <= !stat.word_pads;
        end
        else if (cmd.emit_pad)
        begin
            out_sel_reg  <= SEL_DATA;
            out_word_reg <= '0;
            out_last_reg <= stat.pad_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign stream_sel = out_sel_reg;
    assign word_out   = out_word_reg;
    assign last       = out_last_reg;

    `LBF_ASSERT_NOW(a_no_overwrite, emit_any, out_free)
    `LBF_ASSERT_NOW(a_hdr_pending, cmd.emit_hdr, hdr_pending_reg)
    `LBF_ASSERT_NOW(a_word_open, cmd.emit_word, words_left_reg != '0)
    `LBF_ASSERT_NOW(a_pad_tail, cmd.emit_pad, words_left_reg == '0 && frame_pos_reg != '0)
    `LBF_ASSERT_NEXT(a_hdr_clear, cmd.emit_hdr && stat.hdr_last, !hdr_pending_reg)

endmodule

>>> rtl/link_block_framer.sv
// top level of the link block framer
// start item: 8 * (empty_before + empty_after + 1) beats, one per cycle while not
// stalled; accept goes to the state register, first beat then to the output register;
// data item: headers + 1 + padding beats, one per cycle while not stalled; one item in
// flight, the next is taken the cycle after its last beat is loaded into the output
// register; rst_n async active low: no block open, both empty frame counts back to 2
module link_block_framer
    import lbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic [BYTES_W-1:0]   block_bytes,
    input  logic [WORD_W-1:0]    data_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 stream_sel,
    output logic [WORD_W-1:0]    word_out,
    output logic                 last
);

    lbf_cmd_t  cmd;
    lbf_stat_t stat;

    lbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    lbf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .block_bytes (block_bytes),
        .data_word   (data_word),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .stream_sel  (stream_sel),
        .word_out    (word_out),
        .last        (last),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
